[rtl/msd_pkg.sv]
// Shared constants, types and config codes for the masked segment distance map.
package msd_pkg;

	// Coordinate format and image size
	localparam int COORD_FRAC_BITS = 4;
	localparam int MAX_IMAGE_DIM   = 4096;
	localparam int PIX_W           = 12;
	localparam int REG_W           = 18;
	localparam int CFG_IDX_W       = 3;
	localparam int MASK_W          = 8;
	localparam logic [MASK_W-1:0] MASK_FULL = '1;

	// Datapath widths
	localparam int DIFF_W = REG_W + 1;          // coordinate differences
	localparam int PROD_W = 2 * DIFF_W;         // products of differences
	localparam int DW     = PROD_W;             // divisor (squared segment length)
	localparam int MAG_W  = PROD_W;             // cross product magnitude
	localparam int C_W    = MAG_W + 8;          // magnitude times 255
	localparam int HALF_W = (C_W + 1) / 2;      // split of c for partial products
	localparam int NW     = 2 * C_W;            // dividend
	localparam int QW     = 53;                 // quotient: 65025 * distance^2
	localparam int RW     = (QW + 1) / 2;       // integer square root
	localparam int LW     = REG_W;              // norm length
	localparam int GW     = 8;                  // grey level

	// Pipeline depth
	localparam int FRONT_STAGES = 6;
	localparam int SCALE_STAGES = GW + 1;
	localparam int LATENCY      = FRONT_STAGES + QW + RW + SCALE_STAGES + 1;

	// Config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEG_START_X = 3'd0,
		CFG_SEG_START_Y = 3'd1,
		CFG_SEG_END_X   = 3'd2,
		CFG_SEG_END_Y   = 3'd3,
		CFG_NORM_LENGTH = 3'd4
	} cfg_idx_t;

	// Sideband that travels with each beat
	typedef struct packed {
		logic valid;
		logic in_mask;
	} side_t;

endpackage

[rtl/msd_front.sv]
// Geometry front end: differences, products, case select and dividend setup.
module msd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msd_pkg::side_t                    side_in,
	input  logic [msd_pkg::PIX_W-1:0]         pixel_x,
	input  logic [msd_pkg::PIX_W-1:0]         pixel_y,
	input  logic signed [msd_pkg::REG_W-1:0]  seg_start_x,
	input  logic signed [msd_pkg::REG_W-1:0]  seg_start_y,
	input  logic signed [msd_pkg::REG_W-1:0]  seg_end_x,
	input  logic signed [msd_pkg::REG_W-1:0]  seg_end_y,
	output msd_pkg::side_t                    side_out,
	output logic [msd_pkg::NW-1:0]            num,
	output logic [msd_pkg::DW-1:0]            den
);

	localparam int DIFF_W = msd_pkg::DIFF_W;
	localparam int PROD_W = msd_pkg::PROD_W;
	localparam int C_W    = msd_pkg::C_W;
	localparam int HALF_W = msd_pkg::HALF_W;
	localparam int NW     = msd_pkg::NW;
	localparam int DW     = msd_pkg::DW;
	localparam int PIX_W  = msd_pkg::PIX_W;
	localparam int LO_W   = C_W - HALF_W;
	localparam int R_W    = PROD_W + 16;

	// Clamp a pixel index to the image and place it on the fixed point grid
	function automatic logic signed [DIFF_W-1:0] to_coord(input logic [PIX_W-1:0] v);
		logic [PIX_W-1:0] c;
		c = v;
		if ({1'b0, v} >= (PIX_W+1)'(msd_pkg::MAX_IMAGE_DIM))
			c = PIX_W'(msd_pkg::MAX_IMAGE_DIM - 1);
		return $signed(DIFF_W'({c, {msd_pkg::COORD_FRAC_BITS{1'b0}}}));
	endfunction

	msd_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic signed [DIFF_W-1:0] px, py;
	logic signed [DIFF_W-1:0] vx_s1, vy_s1, wx_s1, wy_s1, ux_s1, uy_s1;
	logic signed [PROD_W-1:0] vxx_s2, vyy_s2, wxx_s2, wyy_s2, uxx_s2, uyy_s2;
	logic signed [PROD_W-1:0] vxux_s2, vyuy_s2, vxuy_s2, vyux_s2;
	logic [DW-1:0]            len2_s3, d2v_s3, d2w_s3;
	logic signed [PROD_W:0]   dot_s3, cross_s3;
	logic                     on_seg_s4;
	logic [DW-1:0]            len2_s4, d2_s4;
	logic [C_W-1:0]           c_s4;
	logic                     on_seg_s5;
	logic [DW-1:0]            len2_s5;
	logic [R_W-1:0]           r_s5;
	logic [2*HALF_W-1:0]      hh_s5;
	logic [HALF_W+LO_W-1:0]   hl_s5;
	logic [2*LO_W-1:0]        ll_s5;
	logic [NW-1:0]            num_s6;
	logic [DW-1:0]            den_s6;

	logic                     sel_start, sel_end;
	logic [PROD_W-1:0]        cross_mag;
	logic [DW-1:0]            d2_sel;

	assign px = to_coord(pixel_x);
	assign py = to_coord(pixel_y);

	// Choose start, end or interior projection
	always_comb begin
		sel_start = (len2_s3 == '0) || (dot_s3 <= 0);
		sel_end   = dot_s3 >= $signed({2'b00, len2_s3});
		cross_mag = cross_s3[PROD_W] ? PROD_W'(-cross_s3) : PROD_W'(cross_s3);
		d2_sel    = sel_start ? d2v_s3 : d2w_s3;
	end

	// Advance sideband valid and mask bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
		end else begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		// differences
		vx_s1 <= px - DIFF_W'(seg_start_x);
		vy_s1 <= py - DIFF_W'(seg_start_y);
		wx_s1 <= px - DIFF_W'(seg_end_x);
		wy_s1 <= py - DIFF_W'(seg_end_y);
		ux_s1 <= DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
		uy_s1 <= DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
		// products
		vxx_s2  <= vx_s1 * vx_s1;
		vyy_s2  <= vy_s1 * vy_s1;
		wxx_s2  <= wx_s1 * wx_s1;
		wyy_s2  <= wy_s1 * wy_s1;
		uxx_s2  <= ux_s1 * ux_s1;
		uyy_s2  <= uy_s1 * uy_s1;
		vxux_s2 <= vx_s1 * ux_s1;
		vyuy_s2 <= vy_s1 * uy_s1;
		vxuy_s2 <= vx_s1 * uy_s1;
		vyux_s2 <= vy_s1 * ux_s1;
		// sums
		len2_s3  <= $unsigned(uxx_s2) + $unsigned(uyy_s2);
		d2v_s3   <= $unsigned(vxx_s2) + $unsigned(vyy_s2);
		d2w_s3   <= $unsigned(wxx_s2) + $unsigned(wyy_s2);
		dot_s3   <= {vxux_s2[PROD_W-1], vxux_s2} + {vyuy_s2[PROD_W-1], vyuy_s2};
		cross_s3 <= {vxuy_s2[PROD_W-1], vxuy_s2} - {vyux_s2[PROD_W-1], vyux_s2};
		// case select, cross magnitude times 255
		on_seg_s4 <= !sel_start && !sel_end;
		len2_s4   <= len2_s3;
		d2_s4     <= d2_sel;
		c_s4      <= {cross_mag, 8'h00} - C_W'(cross_mag);
		// partial products of c squared; endpoint distance times 65025
		on_seg_s5 <= on_seg_s4;
		len2_s5   <= len2_s4;
		hh_s5     <= c_s4[C_W-1:LO_W] * c_s4[C_W-1:LO_W];
		hl_s5     <= c_s4[C_W-1:LO_W] * c_s4[LO_W-1:0];
		ll_s5     <= c_s4[LO_W-1:0] * c_s4[LO_W-1:0];
		r_s5      <= {d2_s4, 16'h0000} - {7'd0, d2_s4, 9'd0} + R_W'(d2_s4);
		// dividend and divisor
		if (on_seg_s5) begin
			num_s6 <= {hh_s5, {(2*LO_W){1'b0}}} + NW'({hl_s5, {(LO_W+1){1'b0}}})
				+ NW'(ll_s5);
			den_s6 <= len2_s5;
		end else begin
			num_s6 <= NW'(r_s5);
			den_s6 <= DW'(1);
		end
	end

	assign side_out = side_s6;
	assign num      = num_s6;
	assign den      = den_s6;

endmodule

[rtl/msd_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module msd_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  msd_pkg::side_t          side_in,
	input  logic [msd_pkg::NW-1:0]  num,
	input  logic [msd_pkg::DW-1:0]  den,
	output msd_pkg::side_t          side_out,
	output logic [msd_pkg::QW-1:0]  quo
);

	localparam int NW = msd_pkg::NW;
	localparam int DW = msd_pkg::DW;
	localparam int QW = msd_pkg::QW;

	// Stage 0 is the input; stage i+1 is registered after bit i
	msd_pkg::side_t side_s [QW+1];
	logic [DW:0]    rem_s  [QW+1];
	logic [QW-1:0]  wrd_s  [QW+1];
	logic [DW-1:0]  den_s  [QW+1];

	assign side_s[0] = side_in;
	assign rem_s[0]  = (DW+1)'(num[NW-1:QW]);
	assign wrd_s[0]  = num[QW-1:0];
	assign den_s[0]  = den;

	for (genvar i = 0; i < QW; i++) begin : g_bit
		logic [DW+1:0] trial;
		logic          ge;

		// Shift in the next dividend bit and try a subtract
		always_comb begin
			trial = {rem_s[i], wrd_s[i][QW-1]};
			ge    = trial >= (DW+2)'(den_s[i]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				side_s[i+1] <= '0;
			else
				side_s[i+1] <= side_s[i];
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? (DW+1)'(trial - (DW+2)'(den_s[i])) : (DW+1)'(trial);
			wrd_s[i+1] <= {wrd_s[i][QW-2:0], ge};
			den_s[i+1] <= den_s[i];
		end
	end

	assign side_out = side_s[QW];
	assign quo      = wrd_s[QW];

endmodule

[rtl/msd_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module msd_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  msd_pkg::side_t          side_in,
	input  logic [msd_pkg::QW-1:0]  rad,
	output msd_pkg::side_t          side_out,
	output logic [msd_pkg::RW-1:0]  root
);

	localparam int RW = msd_pkg::RW;

	msd_pkg::side_t side_s [RW+1];
	logic [RW+1:0]  rem_s  [RW+1];
	logic [2*RW-1:0] wrd_s [RW+1];
	logic [RW-1:0]  root_s [RW+1];

	assign side_s[0] = side_in;
	assign rem_s[0]  = '0;
	assign wrd_s[0]  = (2*RW)'(rad);
	assign root_s[0] = '0;

	for (genvar i = 0; i < RW; i++) begin : g_bit
		logic [RW+3:0] t;
		logic [RW+3:0] trial;
		logic          ge;

		// Bring down two radicand bits and test root*4+1
		always_comb begin
			t     = {rem_s[i], wrd_s[i][2*RW-1 -: 2]};
			trial = (RW+4)'({root_s[i], 2'b01});
			ge    = t >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				side_s[i+1] <= '0;
			else
				side_s[i+1] <= side_s[i];
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
			wrd_s[i+1]  <= {wrd_s[i][2*RW-3:0], 2'b00};
			root_s[i+1] <= {root_s[i][RW-2:0], ge};
		end
	end

	assign side_out = side_s[RW];
	assign root     = root_s[RW];

endmodule

[rtl/msd_scale.sv]
// Saturating divide of the scaled distance by the norm length.
module msd_scale (
	input  logic                    clk,
	input  logic                    arst_n,
	input  msd_pkg::side_t          side_in,
	input  logic [msd_pkg::RW-1:0]  root,
	input  logic [msd_pkg::LW-1:0]  norm_length,
	output msd_pkg::side_t          side_out,
	output logic [msd_pkg::GW-1:0]  grey_lvl
);

	localparam int RW = msd_pkg::RW;
	localparam int GW = msd_pkg::GW;

	msd_pkg::side_t side_s [GW+1];
	logic           sat_s  [GW+1];
	logic [RW-1:0]  rem_s  [GW+1];
	logic [GW-1:0]  q_s    [GW+1];

	// Saturate when the root reaches 256 times the norm length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s[0] <= '0;
		else
			side_s[0] <= side_in;
	end

	always_ff @(posedge clk) begin
		sat_s[0] <= root >= RW'({norm_length, {GW{1'b0}}});
		rem_s[0] <= root;
		q_s[0]   <= '0;
	end

	for (genvar j = 0; j < GW; j++) begin : g_bit
		localparam int K = GW - 1 - j;
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			trial = RW'(norm_length) << K;
			ge    = rem_s[j] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				side_s[j+1] <= '0;
			else
				side_s[j+1] <= side_s[j];
		end

		always_ff @(posedge clk) begin
			sat_s[j+1] <= sat_s[j];
			rem_s[j+1] <= ge ? rem_s[j] - trial : rem_s[j];
			q_s[j+1]   <= {q_s[j][GW-2:0], ge};
		end
	end

	assign side_out = side_s[GW];
	assign grey_lvl = sat_s[GW] ? '1 : q_s[GW];

endmodule

[rtl/masked_segment_distance_map.sv]
// Top level: config registers, pixel distance pipeline and result beat.
// Each accepted pixel gives exactly one result strobe.
// Throughput: one pixel per clock; busy stays low and the pipeline never stalls.
// Most of the depth comes from the 53-stage divider and the 27-stage square root.
// Reset clears all valid bits and loads the segment to zero and norm_length to 16.
module masked_segment_distance_map (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [msd_pkg::PIX_W-1:0]           pixel_x,
	input  logic [msd_pkg::PIX_W-1:0]           pixel_y,
	input  logic [msd_pkg::MASK_W-1:0]          mask_green,
	input  logic                                cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msd_pkg::REG_W-1:0]           cfg_data,
	output logic                                done,
	output logic [msd_pkg::GW-1:0]              grey,
	output logic                                in_mask
);

	localparam int REG_W = msd_pkg::REG_W;

	logic signed [REG_W-1:0] seg_start_x_q, seg_start_y_q, seg_end_x_q, seg_end_y_q;
	logic [REG_W-1:0]        norm_length_q;

	msd_pkg::side_t          side_in, side_f, side_d, side_r, side_g;
	logic [msd_pkg::NW-1:0]  num;
	logic [msd_pkg::DW-1:0]  den;
	logic [msd_pkg::QW-1:0]  quo;
	logic [msd_pkg::RW-1:0]  root;
	logic [msd_pkg::GW-1:0]  grey_lvl;
	logic                    done_q, in_mask_q;
	logic [msd_pkg::GW-1:0]  grey_q;

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_x_q <= '0;
			seg_start_y_q <= '0;
			seg_end_x_q   <= '0;
			seg_end_y_q   <= '0;
			norm_length_q <= REG_W'(16);
		end else if (cfg_we) begin
			unique case (msd_pkg::cfg_idx_t'(cfg_index))
				msd_pkg::CFG_SEG_START_X: seg_start_x_q <= cfg_data;
				msd_pkg::CFG_SEG_START_Y: seg_start_y_q <= cfg_data;
				msd_pkg::CFG_SEG_END_X:   seg_end_x_q   <= cfg_data;
				msd_pkg::CFG_SEG_END_Y:   seg_end_y_q   <= cfg_data;
				msd_pkg::CFG_NORM_LENGTH: norm_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Enter a beat every cycle
	assign busy            = 1'b0;
	assign side_in.valid   = start;
	assign side_in.in_mask = (mask_green == msd_pkg::MASK_FULL);

	msd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.side_in     (side_in),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.seg_start_x (seg_start_x_q),
		.seg_start_y (seg_start_y_q),
		.seg_end_x   (seg_end_x_q),
		.seg_end_y   (seg_end_y_q),
		.side_out    (side_f),
		.num         (num),
		.den         (den)
	);

	msd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_f),
		.num      (num),
		.den      (den),
		.side_out (side_d),
		.quo      (quo)
	);

	msd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_d),
		.rad      (quo),
		.side_out (side_r),
		.root     (root)
	);

	msd_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.side_in     (side_r),
		.root        (root),
		.norm_length (norm_length_q),
		.side_out    (side_g),
		.grey_lvl    (grey_lvl)
	);

	// Result beat: drop grey outside the mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= side_g.valid;
	end

	always_ff @(posedge clk) begin
		in_mask_q <= side_g.in_mask;
		grey_q    <= side_g.in_mask ? grey_lvl : '0;
	end

	assign done    = done_q;
	assign grey    = grey_q;
	assign in_mask = in_mask_q;

	// Every accepted pixel gives one beat after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(msd_pkg::LATENCY) done)
		else $error("result beat missing after accept");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, msd_pkg::LATENCY))
		else $error("result beat without matching accept");

	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_mask |-> grey == '0)
		else $error("nonzero grey outside mask");

endmodule
